### sv/gats_pkg.sv
// Shared types, constants and helper functions for the grid A* target search block.
// No dependencies; every other file imports this package.
package gats_pkg;

  localparam int GRID_W     = 8;
  localparam int GRID_H     = 8;
  // Must be a power of two: the open list is a ring indexed by wrapping pointers.
  localparam int OPEN_DEPTH = 256;

  localparam int NCELLS  = GRID_W * GRID_H;
  localparam int CELL_AW = $clog2(NCELLS);
  localparam int OPEN_AW = $clog2(OPEN_DEPTH);
  localparam int CNT_W   = OPEN_AW + 1;
  localparam int COORD_W = 3;
  localparam int COST_W  = 8;
  localparam int H_W     = COORD_W + 1;
  localparam int F_W     = COST_W + 1;
  localparam int DIR_W   = 3;
  localparam logic [DIR_W-1:0] DIR_COUNT = DIR_W'(4);

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_WALL    = 2'd2,
    KIND_TARGET  = 2'd3
  } cell_kind_e;

  typedef enum logic [1:0] {
    RES_FOUND    = 2'd0,
    RES_NOPATH   = 2'd1,
    RES_OVERFLOW = 2'd2
  } res_status_e;

  typedef enum logic [1:0] {
    POS_ZERO = 2'd0,
    POS_CUR  = 2'd1,
    POS_NB   = 2'd2
  } pos_sel_e;

  typedef struct packed {
    logic [F_W-1:0]     f;
    logic [H_W-1:0]     h;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } open_entry_t;

  typedef struct packed {
    logic        load_we;
    logic        search_start;
    logic        init;
    logic        pop_rd;
    logic        cur_rd;
    logic        pop_commit;
    logic        nb_rd;
    logic        nb_step;
    logic        resolve_wall;
    logic        resolve_clear;
    logic        ins_start;
    logic        ins_rd;
    logic        ins_shift;
    logic        ins_place;
    logic        set_res;
    res_status_e res_code;
    pos_sel_e    res_pos;
    logic        res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       start_oob;
    logic       count_zero;
    logic       cur_target;
    logic       dir_done;
    logic       nb_oob;
    logic       nb_target;
    logic       nb_skip_cost;
    cell_kind_e nb_kind;
    logic       nb_occ;
    logic       list_full;
    logic       j_zero;
    logic       ins_before;
    logic       out_full;
  } dp_sts_t;

  function automatic logic [CELL_AW-1:0] cell_idx(logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y);
    return CELL_AW'(y) * CELL_AW'(GRID_W) + CELL_AW'(x);
  endfunction

  function automatic logic [H_W-1:0] manhattan(logic [COORD_W-1:0] ax,
                                               logic [COORD_W-1:0] ay,
                                               logic [COORD_W-1:0] bx,
                                               logic [COORD_W-1:0] by);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return H_W'(dx) + H_W'(dy);
  endfunction

endpackage

### sv/gats_ctrl.sv
// Sequencer for the grid A* search: pop, neighbour scan, sorted insert, result hand-off.
// Depends on gats_pkg; drives gats_dp through dp_cmd_t and reads dp_sts_t.
module gats_ctrl import gats_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    mode_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_INIT = 10'b0000000010,
    ST_POP  = 10'b0000000100,
    ST_POPW = 10'b0000001000,
    ST_CURW = 10'b0000010000,
    ST_NB   = 10'b0000100000,
    ST_NBW  = 10'b0001000000,
    ST_INS  = 10'b0010000000,
    ST_INSW = 10'b0100000000,
    ST_RES  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i) begin
            cmd_o.search_start = 1'b1;
            state_d = ST_INIT;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_INIT: begin
        if (sts_i.start_oob) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = RES_NOPATH;
          cmd_o.res_pos  = POS_ZERO;
          state_d = ST_RES;
        end else begin
          cmd_o.init = 1'b1;
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (sts_i.count_zero) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = RES_NOPATH;
          cmd_o.res_pos  = POS_ZERO;
          state_d = ST_RES;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        cmd_o.cur_rd = 1'b1;
        state_d = ST_CURW;
      end
      ST_CURW: begin
        if (sts_i.cur_target) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = RES_FOUND;
          cmd_o.res_pos  = POS_CUR;
          state_d = ST_RES;
        end else begin
          cmd_o.pop_commit = 1'b1;
          state_d = ST_NB;
        end
      end
      ST_NB: begin
        if (sts_i.dir_done) begin
          state_d = ST_POP;
        end else if (sts_i.nb_oob) begin
          cmd_o.nb_step = 1'b1;
        end else begin
          cmd_o.nb_rd = 1'b1;
          state_d = ST_NBW;
        end
      end
      ST_NBW: begin
        if (sts_i.nb_target) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = RES_FOUND;
          cmd_o.res_pos  = POS_NB;
          state_d = ST_RES;
        end else if (sts_i.nb_skip_cost || sts_i.nb_kind == KIND_WALL ||
                     (sts_i.nb_kind == KIND_UNKNOWN && sts_i.nb_occ)) begin
          // Cache the resolved wall for an unknown cell, then move on.
          cmd_o.resolve_wall = !sts_i.nb_skip_cost && sts_i.nb_kind == KIND_UNKNOWN;
          cmd_o.nb_step = 1'b1;
          state_d = ST_NB;
        end else begin
          cmd_o.resolve_clear = (sts_i.nb_kind == KIND_UNKNOWN);
          cmd_o.ins_start = 1'b1;
          if (sts_i.list_full) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = RES_OVERFLOW;
            cmd_o.res_pos  = POS_ZERO;
            state_d = ST_RES;
          end else begin
            state_d = ST_INS;
          end
        end
      end
      ST_INS: begin
        if (sts_i.j_zero) begin
          cmd_o.ins_place = 1'b1;
          cmd_o.nb_step   = 1'b1;
          state_d = ST_NB;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d = ST_INSW;
        end
      end
      ST_INSW: begin
        if (sts_i.ins_before) begin
          cmd_o.ins_shift = 1'b1;
          state_d = ST_INS;
        end else begin
          cmd_o.ins_place = 1'b1;
          cmd_o.nb_step   = 1'b1;
          state_d = ST_NB;
        end
      end
      ST_RES: begin
        if (!sts_i.out_full) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/gats_dp.sv
// Datapath of the grid A* search: cell map, path cost map, ring-buffer open list,
// neighbour generation and the result register. Depends on gats_pkg.
module gats_dp import gats_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [COORD_W-1:0] cell_x_i,
  input  logic [COORD_W-1:0] cell_y_i,
  input  logic [1:0]         cell_kind_i,
  input  logic               cell_occupied_i,
  input  logic [COORD_W-1:0] start_x_i,
  input  logic [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0] goal_x_i,
  input  logic [COORD_W-1:0] goal_y_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [COORD_W-1:0] end_x_o,
  output logic [COORD_W-1:0] end_y_o
);

  // Cell map: {occupied, kind}; an entry without its valid bit reads as unknown, free.
  logic [2:0]         map_mem [NCELLS];
  logic [NCELLS-1:0]  map_vld_q;
  logic [2:0]         map_rd_q;
  logic               map_rd_vld_q;
  logic [COST_W-1:0]  cost_mem [NCELLS];
  logic [NCELLS-1:0]  cost_vld_q;
  logic [COST_W-1:0]  cost_rd_q;
  logic               cost_rd_vld_q;
  open_entry_t        open_mem [OPEN_DEPTH];
  open_entry_t        open_rd_q;

  logic [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q;
  logic [COORD_W-1:0] cur_x_q, cur_y_q;
  logic [COST_W-1:0]  g_q;
  logic [DIR_W-1:0]   dir_q;
  logic [OPEN_AW-1:0] head_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   j_q;
  open_entry_t        ent_q;
  res_status_e        pend_status_q;
  logic [COORD_W-1:0] pend_x_q, pend_y_q;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [COORD_W-1:0] end_x_q, end_y_q;

  logic [COORD_W-1:0] nx, ny;
  logic               nb_oob;
  logic [CELL_AW-1:0] nb_cell, map_ra, map_wa, cost_wa;
  logic               map_we, cost_we;
  logic [2:0]         map_wd;
  logic [COST_W-1:0]  cost_wd;
  logic [COST_W:0]    tg;
  logic [H_W-1:0]     nb_h, start_h;
  logic [OPEN_AW-1:0] open_ra, open_wa, ins_at;
  logic               open_we;
  open_entry_t        open_wd, start_ent;
  cell_kind_e         nb_kind;

  // Neighbour order: right, down, left, up.
  always_comb begin
    nx     = cur_x_q;
    ny     = cur_y_q;
    nb_oob = 1'b1;
    case (dir_q)
      DIR_W'(0): begin
        nx     = cur_x_q + 1'b1;
        nb_oob = (int'(cur_x_q) >= GRID_W - 1);
      end
      DIR_W'(1): begin
        ny     = cur_y_q + 1'b1;
        nb_oob = (int'(cur_y_q) >= GRID_H - 1);
      end
      DIR_W'(2): begin
        nx     = cur_x_q - 1'b1;
        nb_oob = (cur_x_q == '0);
      end
      DIR_W'(3): begin
        ny     = cur_y_q - 1'b1;
        nb_oob = (cur_y_q == '0);
      end
      default: begin
        nb_oob = 1'b1;
      end
    endcase
  end

  assign nb_cell = cell_idx(nx, ny);
  assign tg      = {1'b0, g_q} + 1'b1;
  assign nb_h    = manhattan(nx, ny, gx_q, gy_q);
  assign start_h = manhattan(sx_q, sy_q, gx_q, gy_q);
  assign nb_kind = map_rd_vld_q ? cell_kind_e'(map_rd_q[1:0]) : KIND_UNKNOWN;
  assign ins_at  = OPEN_AW'(CNT_W'(head_q) + j_q);

  always_comb begin
    start_ent.f = F_W'(start_h);
    start_ent.h = start_h;
    start_ent.x = sx_q;
    start_ent.y = sy_q;
  end

  // Map port: one shared read address for the kind and cost maps.
  always_comb begin
    if (cmd_i.cur_rd) begin
      map_ra = cell_idx(open_rd_q.x, open_rd_q.y);
    end else begin
      map_ra = nb_cell;
    end
    map_we = cmd_i.load_we || cmd_i.resolve_wall || cmd_i.resolve_clear;
    if (cmd_i.load_we) begin
      map_wa = cell_idx(cell_x_i, cell_y_i);
      map_wd = {cell_occupied_i, cell_kind_i};
    end else begin
      map_wa = nb_cell;
      map_wd = {map_rd_vld_q && map_rd_q[2], cmd_i.resolve_wall ? KIND_WALL : KIND_CLEAR};
    end
    if (cmd_i.load_we && (int'(cell_x_i) >= GRID_W || int'(cell_y_i) >= GRID_H)) begin
      map_we = 1'b0;
    end
    cost_we = cmd_i.init || cmd_i.ins_start;
    if (cmd_i.init) begin
      cost_wa = cell_idx(sx_q, sy_q);
      cost_wd = '0;
    end else begin
      cost_wa = nb_cell;
      cost_wd = tg[COST_W-1:0];
    end
  end

  always_comb begin
    open_ra = cmd_i.ins_rd ? OPEN_AW'(CNT_W'(head_q) + j_q - 1'b1) : head_q;
    open_we = cmd_i.init || cmd_i.ins_shift || cmd_i.ins_place;
    open_wa = cmd_i.init ? head_q : ins_at;
    if (cmd_i.init) begin
      open_wd = start_ent;
    end else if (cmd_i.ins_shift) begin
      open_wd = open_rd_q;
    end else begin
      open_wd = ent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (cost_we) begin
      cost_mem[cost_wa] <= cost_wd;
    end
    // Hold the read data between the read commands.
    if (cmd_i.cur_rd || cmd_i.nb_rd) begin
      map_rd_q  <= map_mem[map_ra];
      cost_rd_q <= cost_mem[map_ra];
    end
    if (open_we) begin
      open_mem[open_wa] <= open_wd;
    end
    if (cmd_i.pop_rd || cmd_i.ins_rd) begin
      open_rd_q <= open_mem[open_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q     <= '0;
      cost_vld_q    <= '0;
      map_rd_vld_q  <= 1'b0;
      cost_rd_vld_q <= 1'b0;
    end else begin
      if (map_we) begin
        map_vld_q[map_wa] <= 1'b1;
      end
      if (cmd_i.search_start) begin
        cost_vld_q <= '0;
      end else if (cost_we) begin
        cost_vld_q[cost_wa] <= 1'b1;
      end
      if (cmd_i.cur_rd || cmd_i.nb_rd) begin
        map_rd_vld_q  <= map_vld_q[map_ra];
        cost_rd_vld_q <= cost_vld_q[map_ra];
      end
    end
  end

  // Search registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      j_q     <= '0;
      dir_q   <= '0;
    end else begin
      if (cmd_i.search_start) begin
        head_q  <= '0;
        count_q <= '0;
      end
      if (cmd_i.init) begin
        count_q <= CNT_W'(1);
      end
      if (cmd_i.pop_commit) begin
        head_q  <= head_q + 1'b1;
        count_q <= count_q - 1'b1;
        dir_q   <= '0;
      end
      if (cmd_i.nb_step) begin
        dir_q <= dir_q + 1'b1;
      end
      if (cmd_i.ins_start) begin
        j_q <= count_q;
      end
      if (cmd_i.ins_shift) begin
        j_q <= j_q - 1'b1;
      end
      if (cmd_i.ins_place) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_start) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      gx_q <= goal_x_i;
      gy_q <= goal_y_i;
    end
    if (cmd_i.cur_rd) begin
      cur_x_q <= open_rd_q.x;
      cur_y_q <= open_rd_q.y;
    end
    if (cmd_i.pop_commit) begin
      g_q <= cost_rd_q;
    end
    if (cmd_i.ins_start) begin
      ent_q.f <= F_W'(tg) + F_W'(nb_h);
      ent_q.h <= nb_h;
      ent_q.x <= nx;
      ent_q.y <= ny;
    end
    if (cmd_i.set_res) begin
      pend_status_q <= cmd_i.res_code;
      case (cmd_i.res_pos)
        POS_CUR: begin
          pend_x_q <= cur_x_q;
          pend_y_q <= cur_y_q;
        end
        POS_NB: begin
          pend_x_q <= nx;
          pend_y_q <= ny;
        end
        default: begin
          pend_x_q <= '0;
          pend_y_q <= '0;
        end
      endcase
    end
    if (cmd_i.res_load) begin
      status_q <= pend_status_q;
      end_x_q  <= pend_x_q;
      end_y_q  <= pend_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign end_x_o     = end_x_q;
  assign end_y_o     = end_y_q;

  always_comb begin
    sts_o.start_oob    = (int'(sx_q) >= GRID_W) || (int'(sy_q) >= GRID_H);
    sts_o.count_zero   = (count_q == '0);
    sts_o.cur_target   = map_rd_vld_q && (map_rd_q[1:0] == KIND_TARGET);
    sts_o.dir_done     = (dir_q >= DIR_COUNT);
    sts_o.nb_oob       = nb_oob;
    sts_o.nb_target    = (nb_kind == KIND_TARGET);
    sts_o.nb_skip_cost = cost_rd_vld_q && (tg >= {1'b0, cost_rd_q});
    sts_o.nb_kind      = nb_kind;
    sts_o.nb_occ       = map_rd_vld_q && map_rd_q[2];
    sts_o.list_full    = (count_q == CNT_W'(OPEN_DEPTH));
    sts_o.j_zero       = (j_q == '0);
    sts_o.ins_before   = (ent_q.f < open_rd_q.f) ||
                         ((ent_q.f == open_rd_q.f) && (ent_q.h <= open_rd_q.h));
    sts_o.out_full     = out_valid_q && !out_ready_i;
  end

endmodule

### sv/grid_astar_target_search_core.sv
// Top level of the grid A* target search: joins the sequencer and the datapath.
// Depends on gats_pkg, gats_ctrl and gats_dp.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   in      | input     | in_valid_i/in_ready_o | mode, cell_x/y, cell_kind, cell_occupied,
//           |           |                       | start_x/y, goal_x/y
//   out     | output    | out_valid_o/out_ready_i| status, end_x, end_y
//
// A load is a single cell-map write. A search pops cells, reads each neighbour and
// shifts open-list entries on each sorted insert; the open-list memory and its
// tail-to-head insertion walk set how long a search takes.
// Reset clears the valid bits of the cell map, so every cell reads unknown and free.
// A finished result waits in the output register; the next item is taken meanwhile,
// and a later search holds its result until the register frees.
module grid_astar_target_search_core import gats_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [2:0]         cell_x_i,
  input  logic [2:0]         cell_y_i,
  input  logic [1:0]         cell_kind_i,
  input  logic               cell_occupied_i,
  input  logic [2:0]         start_x_i,
  input  logic [2:0]         start_y_i,
  input  logic [2:0]         goal_x_i,
  input  logic [2:0]         goal_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [2:0]         end_x_o,
  output logic [2:0]         end_y_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  gats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gats_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_kind_i     (cell_kind_i),
    .cell_occupied_i (cell_occupied_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .goal_x_i        (goal_x_i),
    .goal_y_i        (goal_y_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .end_x_o         (end_x_o),
    .end_y_o         (end_y_o)
  );

endmodule

### sv/gats_checker.sv
// Port-level checks for grid_astar_target_search_core, attached with a bind.
// Depends on gats_pkg and the top level's ports.
module gats_checker import gats_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       mode_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [2:0] end_x_o,
  input logic [2:0] end_y_o
);

  // Hold the result until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(end_x_o) && $stable(end_y_o))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == RES_FOUND || status_o == RES_NOPATH ||
                    status_o == RES_OVERFLOW)
    else $error("undefined status code");

  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != RES_FOUND |-> end_x_o == 3'd0 && end_y_o == 3'd0)
    else $error("position not zero for a failed search");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !mode_i && !out_valid_o |=> !out_valid_o)
    else $error("a load produced a result");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i |=> !in_ready_o)
    else $error("new transaction taken during a search");

endmodule

bind grid_astar_target_search_core gats_checker u_gats_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .end_x_o     (end_x_o),
  .end_y_o     (end_y_o)
);

### tb/tb_top.sv
// Self-checking testbench for grid_astar_target_search_core: map loads and A* searches
// are predicted in a scoreboard class and compared with every accepted result.
// Depends on gats_pkg and the RTL of the search core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gats_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int SHOW_LIMIT  = 10;
  localparam int UNREACHED   = 65535;

  class search_scoreboard;
    typedef struct {
      int f;
      int h;
      int x;
      int y;
    } node_t;

    typedef struct {
      res_status_e status;
      logic [2:0]  x;
      logic [2:0]  y;
    } verdict_t;

    cell_kind_e kind_map[NCELLS];
    bit         occ_map[NCELLS];
    verdict_t   pending[$];
    int         failures;

    function new();
      foreach (kind_map[i]) begin
        kind_map[i] = KIND_UNKNOWN;
        occ_map[i]  = 1'b0;
      end
      failures = 0;
    endfunction

    function int distance(int ax, int ay, int bx, int by);
      return ((ax > bx) ? ax - bx : bx - ax) + ((ay > by) ? ay - by : by - ay);
    endfunction

    function verdict_t make_verdict(res_status_e st, int x, int y);
      verdict_t v;
      v.status = st;
      v.x      = 3'(x);
      v.y      = 3'(y);
      return v;
    endfunction

    function verdict_t run_astar(int sx, int sy, int gx, int gy);
      int    cost[NCELLS];
      node_t frontier[$];
      node_t cur;
      node_t nd;
      int    ci, ni, nx, ny, tg, k;
      foreach (cost[i]) cost[i] = UNREACHED;
      if (sx >= GRID_W || sy >= GRID_H) return make_verdict(RES_NOPATH, 0, 0);
      cost[sy * GRID_W + sx] = 0;
      nd.h = distance(sx, sy, gx, gy);
      nd.f = nd.h;
      nd.x = sx;
      nd.y = sy;
      frontier.push_back(nd);
      while (frontier.size() > 0) begin
        cur = frontier[0];
        ci  = cur.y * GRID_W + cur.x;
        if (kind_map[ci] == KIND_TARGET) return make_verdict(RES_FOUND, cur.x, cur.y);
        void'(frontier.pop_front());
        // right, down, left, up
        for (int d = 0; d < 4; d++) begin
          nx = cur.x + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
          ny = cur.y + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
          if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H) continue;
          ni = ny * GRID_W + nx;
          if (kind_map[ni] == KIND_TARGET) return make_verdict(RES_FOUND, nx, ny);
          tg = cost[ci] + 1;
          if (tg >= cost[ni]) continue;
          if (kind_map[ni] == KIND_UNKNOWN) begin
            // resolve once and keep it in the map
            if (occ_map[ni]) begin
              kind_map[ni] = KIND_WALL;
              continue;
            end
            kind_map[ni] = KIND_CLEAR;
          end else if (kind_map[ni] == KIND_WALL) begin
            continue;
          end
          cost[ni] = tg;
          nd.h = distance(nx, ny, gx, gy);
          nd.f = tg + nd.h;
          nd.x = nx;
          nd.y = ny;
          if (frontier.size() >= OPEN_DEPTH) return make_verdict(RES_OVERFLOW, 0, 0);
          // new entry goes ahead of equal f and h
          for (k = 0; k < frontier.size(); k++) begin
            if (nd.f < frontier[k].f || (nd.f == frontier[k].f && nd.h <= frontier[k].h))
              break;
          end
          frontier.insert(k, nd);
        end
      end
      return make_verdict(RES_NOPATH, 0, 0);
    endfunction

    function void note_input(bit mode, int cx, int cy, int ck, bit co,
                             int sx, int sy, int gx, int gy);
      if (!mode) begin
        if (cx < GRID_W && cy < GRID_H) begin
          kind_map[cy * GRID_W + cx] = cell_kind_e'(ck);
          occ_map[cy * GRID_W + cx]  = co;
        end
      end else begin
        pending.push_back(run_astar(sx, sy, gx, gy));
      end
    endfunction

    function void check_result(logic [1:0] status, logic [2:0] ex, logic [2:0] ey);
      verdict_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("unexpected result: status %0d end (%0d,%0d)", status, ex, ey);
        return;
      end
      want = pending.pop_front();
      if (status !== want.status || ex !== want.x || ey !== want.y) begin
        failures++;
        if (failures <= SHOW_LIMIT)
          $display("mismatch: expected status %0d end (%0d,%0d), got status %0d end (%0d,%0d)",
                   want.status, want.x, want.y, status, ex, ey);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid, in_ready;
  logic       mode;
  logic [2:0] cell_x, cell_y;
  logic [1:0] cell_kind;
  logic       cell_occ;
  logic [2:0] start_x, start_y, goal_x, goal_y;
  logic       out_valid, out_ready;
  logic [1:0] status;
  logic [2:0] end_x, end_y;

  search_scoreboard sb;
  bit calm;
  bit hold_req;
  int items_sent;

  grid_astar_target_search_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .cell_x_i       (cell_x),
    .cell_y_i       (cell_y),
    .cell_kind_i    (cell_kind),
    .cell_occupied_i(cell_occ),
    .start_x_i      (start_x),
    .start_y_i      (start_y),
    .goal_x_i       (goal_x),
    .goal_y_i       (goal_y),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .end_x_o        (end_x),
    .end_y_o        (end_y)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    int n;
    n = 0;
    forever begin
      @(posedge clk);
      n++;
      if (n >= CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(1, 4) - 1;
        out_ready  = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(status, end_x, end_y);
  end

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold the transaction until it is taken, then advance the prediction
  task automatic drive_item(bit m, int cx, int cy, int ck, bit co,
                            int sx, int sy, int gx, int gy);
    sender_gap();
    @(negedge clk);
    mode      = m;
    cell_x    = 3'(cx);
    cell_y    = 3'(cy);
    cell_kind = 2'(ck);
    cell_occ  = co;
    start_x   = 3'(sx);
    start_y   = 3'(sy);
    goal_x    = 3'(gx);
    goal_y    = 3'(gy);
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(m, cx, cy, ck, co, sx, sy, gx, gy);
    items_sent++;
  endtask

  task automatic load_cell(int cx, int cy, cell_kind_e ck, bit co);
    drive_item(1'b0, cx, cy, ck, co, $urandom_range(0, 7), $urandom_range(0, 7),
               $urandom_range(0, 7), $urandom_range(0, 7));
  endtask

  task automatic search(int sx, int sy, int gx, int gy);
    drive_item(1'b1, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 3),
               1'($urandom_range(0, 1)), sx, sy, gx, gy);
  endtask

  task automatic random_episode();
    int         nloads;
    int         nsearch;
    int         r;
    cell_kind_e ck;
    nloads  = $urandom_range(3, 12);
    nsearch = $urandom_range(1, 2);
    repeat (nloads) begin
      r = $urandom_range(0, 9);
      ck = (r < 4) ? KIND_CLEAR : (r < 6) ? KIND_WALL : (r < 8) ? KIND_UNKNOWN : KIND_TARGET;
      load_cell($urandom_range(0, 7), $urandom_range(0, 7), ck, 1'($urandom_range(0, 1)));
    end
    repeat (nsearch)
      search($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
             $urandom_range(0, 7));
  endtask

  initial begin
    bit held;
    bit paused;
    sb         = new();
    calm       = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    held       = 1'b0;
    paused     = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    mode       = 1'b0;
    cell_x     = '0;
    cell_y     = '0;
    cell_kind  = '0;
    cell_occ   = 1'b0;
    start_x    = '0;
    start_y    = '0;
    goal_x     = '0;
    goal_y     = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty map, corners, walls, unknown cells, start on target
    search(0, 0, 7, 7);
    load_cell(7, 7, KIND_TARGET, 1'b0);
    load_cell(0, 0, KIND_WALL, 1'b1);
    load_cell(3, 3, KIND_UNKNOWN, 1'b1);
    load_cell(3, 4, KIND_UNKNOWN, 1'b0);
    load_cell(7, 0, KIND_CLEAR, 1'b1);
    load_cell(4, 3, KIND_UNKNOWN, 1'b1);
    search(0, 0, 7, 7);
    search(7, 7, 0, 0);
    search(3, 3, 0, 7);
    search(0, 7, 7, 0);
    load_cell(7, 7, KIND_CLEAR, 1'b1);
    search(0, 0, 0, 0);
    load_cell(0, 7, KIND_TARGET, 1'b1);
    load_cell(1, 7, KIND_WALL, 1'b0);
    load_cell(0, 6, KIND_WALL, 1'b0);
    search(7, 0, 7, 7);
    load_cell(6, 0, KIND_TARGET, 1'b0);
    search(7, 0, 0, 7);
    search(5, 5, 7, 7);

    while (items_sent < 750) begin
      if (!held && items_sent > 250) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && items_sent > 450) begin
        // drain every pending search before going on
        paused = 1'b1;
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() > 0) @(posedge clk);
      end
      if (items_sent > 630) calm = 1'b1;
      random_episode();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
